FILE: hw/rtl/cmst_pkg.sv
`timescale 1ns / 1ps

package cmst_pkg;

    localparam int unsigned SCORE_BITS  = 32;
    localparam int unsigned OUT_BITS    = 32;
    localparam int unsigned NUM_MODES   = 4;
    localparam int unsigned ADD_BITS    = 3;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [ADD_BITS-1:0] SPAN_CEILING = 3'd6;
    localparam logic [ADD_BITS-1:0] UTF_POINT    = 3'd6;
    localparam logic [ADD_BITS-1:0] SIGNED_TOP   = 3'd7;

    typedef enum logic [1:0] {
        MODE_LSB6   = 2'd0,
        MODE_MSB6   = 2'd1,
        MODE_UTF8   = 2'd2,
        MODE_SIGNED = 2'd3
    } t_mode;

    // per-byte work handed from front to back
    typedef struct packed {
        logic                                clear;
        logic [NUM_MODES-1:0][ADD_BITS-1:0]  add;
    } t_incr;

    localparam int unsigned INCR_BITS = $bits(t_incr);

    function automatic logic [3:0] pop8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++) begin
            n = n + {3'd0, v[i]};
        end
        return n;
    endfunction

    // 6 when add beats sub, else 6 + add - sub (never below zero here)
    function automatic logic [ADD_BITS-1:0] ceiling_add(input logic [3:0] sub,
                                                        input logic [3:0] add);
        logic [3:0] t;
        t = {1'b0, SPAN_CEILING} + add - sub;
        if (add > sub) begin
            return SPAN_CEILING;
        end
        return t[ADD_BITS-1:0];
    endfunction

    function automatic logic [2:0] signed_class(input logic [7:0] b);
        logic [2:0] c;
        if (b == 8'd0)            c = 3'd0;
        else if (b < 8'd16)       c = 3'd1;
        else if (b < 8'd64)       c = 3'd2;
        else if (b < 8'd128)      c = 3'd3;
        else if (b < 8'd192)      c = 3'd4;
        else if (b < 8'd240)      c = 3'd5;
        else if (b < 8'd255)      c = 3'd6;
        else                      c = 3'd7;
        return c;
    endfunction

endpackage

FILE: hw/rtl/cmst_front.sv
`timescale 1ns / 1ps

module cmst_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  logic [7:0]         i_data_byte,
    input  logic               i_new_span,
    input  logic               i_clear_scores,
    output cmst_pkg::t_incr    o_incr
);

    logic [7:0] r_prev;
    logic [7:0] n_prev;
    logic [1:0] r_pend;
    logic [1:0] n_pend;

    logic [7:0] w_prev;
    logic [1:0] w_pend;
    logic [7:0] w_x;
    logic [2:0] w_cp;
    logic [2:0] w_cc;
    logic [2:0] w_dist;
    logic       w_utf;

    always_comb begin
        w_prev = i_new_span ? 8'd0 : r_prev;
        w_pend = i_new_span ? 2'd0 : r_pend;
        w_x    = w_prev ^ i_data_byte;
        w_cp   = cmst_pkg::signed_class(w_prev);
        w_cc   = cmst_pkg::signed_class(i_data_byte);
        w_dist = (w_cc > w_cp) ? (w_cc - w_cp) : (w_cp - w_cc);
    end

    // UTF-8 lead / continuation tracking
    always_comb begin
        n_pend = w_pend;
        w_utf  = 1'b0;
        if (w_pend != 2'd0) begin
            if (i_data_byte[7:6] == 2'b10) begin
                n_pend = w_pend - 2'd1;
                w_utf  = 1'b1;
            end else begin
                n_pend = 2'd0;
            end
        end else if (i_data_byte >= 8'hF0) begin
            n_pend = 2'd3;
            w_utf  = 1'b1;
        end else if (i_data_byte >= 8'hE0) begin
            n_pend = 2'd2;
            w_utf  = 1'b1;
        end else if (i_data_byte >= 8'hC0) begin
            n_pend = 2'd1;
            w_utf  = 1'b1;
        end else if (!i_data_byte[7]) begin
            w_utf  = 1'b1;
        end
        n_prev = i_data_byte;
    end

    always_comb begin
        o_incr.clear = i_clear_scores;
        o_incr.add[cmst_pkg::MODE_LSB6] = cmst_pkg::ceiling_add(
            4'd3 * cmst_pkg::pop8(w_x & 8'hC0), cmst_pkg::pop8(w_x & 8'h3F));
        o_incr.add[cmst_pkg::MODE_MSB6] = cmst_pkg::ceiling_add(
            4'd3 * cmst_pkg::pop8(w_x & 8'h03), cmst_pkg::pop8(w_x & 8'hFC));
        o_incr.add[cmst_pkg::MODE_UTF8]   = w_utf ? cmst_pkg::UTF_POINT : 3'd0;
        o_incr.add[cmst_pkg::MODE_SIGNED] = cmst_pkg::SIGNED_TOP - w_dist;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev <= 8'd0;
            r_pend <= 2'd0;
        end else if (i_fire) begin
            r_prev <= n_prev;
            r_pend <= n_pend;
        end
    end

endmodule

FILE: hw/rtl/cmst_queue.sv
`timescale 1ns / 1ps

module cmst_queue #(
    parameter int unsigned WIDTH = cmst_pkg::INCR_BITS,
    parameter int unsigned DEPTH = cmst_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int unsigned PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    r_mem [DEPTH];
    logic [PTR_BITS-1:0] r_wr_ptr;
    logic [PTR_BITS-1:0] n_wr_ptr;
    logic [PTR_BITS-1:0] r_rd_ptr;
    logic [PTR_BITS-1:0] n_rd_ptr;
    logic [CNT_BITS-1:0] r_count;
    logic [CNT_BITS-1:0] n_count;

    assign o_full  = (r_count == CNT_BITS'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_BITS'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_BITS'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_BITS'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CNT_BITS'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CNT_BITS'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hw/rtl/cmst_back.sv
`timescale 1ns / 1ps

module cmst_back #(
    parameter int unsigned SCORE_BITS = cmst_pkg::SCORE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    output logic                  o_q_pop,
    input  cmst_pkg::t_incr       i_incr,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [SCORE_BITS-1:0] o_score [cmst_pkg::NUM_MODES],
    output cmst_pkg::t_mode       o_best_mode
);

    // score registers double as the result register
    logic [SCORE_BITS-1:0] r_score [cmst_pkg::NUM_MODES];
    logic [SCORE_BITS-1:0] n_score [cmst_pkg::NUM_MODES];
    logic                  r_out_valid;
    logic                  n_out_valid;

    logic [SCORE_BITS-1:0] w_max01;
    logic [SCORE_BITS-1:0] w_max23;
    cmst_pkg::t_mode       w_best01;
    cmst_pkg::t_mode       w_best23;

    assign o_q_pop     = i_q_valid && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;

    always_comb begin
        for (int i = 0; i < cmst_pkg::NUM_MODES; i++) begin
            n_score[i] = (i_incr.clear ? '0 : r_score[i]) +
                         SCORE_BITS'(i_incr.add[i]);
        end
        n_out_valid = o_q_pop ? 1'b1 : (r_out_valid && !i_out_ready);
    end

    // first maximum; strict compares keep the lower mode on a tie
    always_comb begin
        if (r_score[cmst_pkg::MODE_MSB6] > r_score[cmst_pkg::MODE_LSB6]) begin
            w_best01 = cmst_pkg::MODE_MSB6;
            w_max01  = r_score[cmst_pkg::MODE_MSB6];
        end else begin
            w_best01 = cmst_pkg::MODE_LSB6;
            w_max01  = r_score[cmst_pkg::MODE_LSB6];
        end
        if (r_score[cmst_pkg::MODE_SIGNED] > r_score[cmst_pkg::MODE_UTF8]) begin
            w_best23 = cmst_pkg::MODE_SIGNED;
            w_max23  = r_score[cmst_pkg::MODE_SIGNED];
        end else begin
            w_best23 = cmst_pkg::MODE_UTF8;
            w_max23  = r_score[cmst_pkg::MODE_UTF8];
        end
        o_best_mode = (w_max23 > w_max01) ? w_best23 : w_best01;
    end

    always_comb begin
        for (int i = 0; i < cmst_pkg::NUM_MODES; i++) begin
            o_score[i] = r_score[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int i = 0; i < cmst_pkg::NUM_MODES; i++) begin
                r_score[i] <= '0;
            end
        end else begin
            r_out_valid <= n_out_valid;
            if (o_q_pop) begin
                for (int i = 0; i < cmst_pkg::NUM_MODES; i++) begin
                    r_score[i] <= n_score[i];
                end
            end
        end
    end

endmodule

FILE: hw/rtl/context_mode_score_tracker_unit.sv
`timescale 1ns / 1ps
// Channel  | Handshake                 | Payload
// ---------+---------------------------+-----------------------------------------
// input    | i_in_valid / o_in_ready   | i_data_byte, i_new_span, i_clear_scores
// output   | o_out_valid / i_out_ready | o_score_lsb6/msb6/utf8/signed, o_best_mode
//
// One byte per cycle sustained while the output is not stalled; each result is registered.
// The front scores the byte against the previous one and pushes the four increments
// into a two-entry queue; the back adds them into the score registers, which are
// also the result register. A stalled output fills the queue, then drops o_in_ready.
// Synchronous active-low reset clears previous byte, pending count and all scores.

module context_mode_score_tracker_unit #(
    parameter int unsigned SCORE_BITS = cmst_pkg::SCORE_BITS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_span,
    input  logic        i_clear_scores,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_score_lsb6,
    output logic [31:0] o_score_msb6,
    output logic [31:0] o_score_utf8,
    output logic [31:0] o_score_signed,
    output logic [1:0]  o_best_mode
);

    logic                  w_in_fire;
    logic                  w_q_full;
    logic                  w_q_valid;
    logic                  w_q_pop;
    cmst_pkg::t_incr       w_front_incr;
    cmst_pkg::t_incr       w_back_incr;
    logic [SCORE_BITS-1:0] w_score [cmst_pkg::NUM_MODES];
    logic [cmst_pkg::OUT_BITS-1:0] w_out [cmst_pkg::NUM_MODES];
    cmst_pkg::t_mode       w_best;

    assign o_in_ready = !w_q_full;
    assign w_in_fire  = i_in_valid && o_in_ready;

    cmst_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_fire         (w_in_fire),
        .i_data_byte    (i_data_byte),
        .i_new_span     (i_new_span),
        .i_clear_scores (i_clear_scores),
        .o_incr         (w_front_incr)
    );

    cmst_queue #(
        .WIDTH (cmst_pkg::INCR_BITS),
        .DEPTH (cmst_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_in_fire),
        .i_data  (w_front_incr),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_back_incr)
    );

    cmst_back #(
        .SCORE_BITS (SCORE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (w_q_valid),
        .o_q_pop     (w_q_pop),
        .i_incr      (w_back_incr),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_score     (w_score),
        .o_best_mode (w_best)
    );

    for (genvar g = 0; g < cmst_pkg::NUM_MODES; g++) begin : g_out
        if (SCORE_BITS >= cmst_pkg::OUT_BITS) begin : g_trunc
            assign w_out[g] = w_score[g][cmst_pkg::OUT_BITS-1:0];
        end else begin : g_ext
            assign w_out[g] = {{(cmst_pkg::OUT_BITS - SCORE_BITS){1'b0}}, w_score[g]};
        end
    end

    assign o_score_lsb6   = w_out[cmst_pkg::MODE_LSB6];
    assign o_score_msb6   = w_out[cmst_pkg::MODE_MSB6];
    assign o_score_utf8   = w_out[cmst_pkg::MODE_UTF8];
    assign o_score_signed = w_out[cmst_pkg::MODE_SIGNED];
    assign o_best_mode    = w_best;

endmodule

FILE: hw/rtl/cmst_checker.sv
`timescale 1ns / 1ps

module cmst_checker #(
    parameter int unsigned SCORE_BITS = cmst_pkg::SCORE_BITS
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_ready,
    input logic [7:0]  i_data_byte,
    input logic        i_new_span,
    input logic        i_clear_scores,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_score_lsb6,
    input logic [31:0] o_score_msb6,
    input logic [31:0] o_score_utf8,
    input logic [31:0] o_score_signed,
    input logic [1:0]  o_best_mode
);

    logic w_best_ok;

    // best mode must be a first maximum of the shown scores
    always_comb begin
        case (o_best_mode)
            cmst_pkg::MODE_LSB6: begin
                w_best_ok = (o_score_lsb6 >= o_score_msb6) &&
                            (o_score_lsb6 >= o_score_utf8) &&
                            (o_score_lsb6 >= o_score_signed);
            end
            cmst_pkg::MODE_MSB6: begin
                w_best_ok = (o_score_msb6 > o_score_lsb6) &&
                            (o_score_msb6 >= o_score_utf8) &&
                            (o_score_msb6 >= o_score_signed);
            end
            cmst_pkg::MODE_UTF8: begin
                w_best_ok = (o_score_utf8 > o_score_lsb6) &&
                            (o_score_utf8 > o_score_msb6) &&
                            (o_score_utf8 >= o_score_signed);
            end
            cmst_pkg::MODE_SIGNED: begin
                w_best_ok = (o_score_signed > o_score_lsb6) &&
                            (o_score_signed > o_score_msb6) &&
                            (o_score_signed > o_score_utf8);
            end
            default: begin
                w_best_ok = 1'b0;
            end
        endcase
    end

    // a stalled result keeps its lsb6 and utf8 scores and best mode until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_score_lsb6) &&
        $stable(o_score_utf8) && $stable(o_best_mode))
        else $error("output result changed while stalled");

    // an offered byte stays put until its transfer
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_ready |=> i_in_valid && $stable(i_data_byte) &&
        $stable(i_new_span) && $stable(i_clear_scores))
        else $error("input byte changed while stalled");

    // the queue fills only behind a waiting result
    a_full_needs_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled with no result waiting");

    // an idle output cannot hold back input
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input not ready while output idle");

    if (SCORE_BITS == cmst_pkg::OUT_BITS) begin : g_best
        a_best_first_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            o_out_valid |-> w_best_ok)
            else $error("best mode is not the first maximum");
    end

endmodule

bind context_mode_score_tracker_unit cmst_checker #(
    .SCORE_BITS (SCORE_BITS)
) u_cmst_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_ready     (o_in_ready),
    .i_data_byte    (i_data_byte),
    .i_new_span     (i_new_span),
    .i_clear_scores (i_clear_scores),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_score_lsb6   (o_score_lsb6),
    .o_score_msb6   (o_score_msb6),
    .o_score_utf8   (o_score_utf8),
    .o_score_signed (o_score_signed),
    .o_best_mode    (o_best_mode)
);

FILE: test/cmst_score_checker.sv
`timescale 1ns / 1ps

module cmst_score_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_new_span,
    input  logic        i_clear_scores,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_score_lsb6,
    input  logic [31:0] i_score_msb6,
    input  logic [31:0] i_score_utf8,
    input  logic [31:0] i_score_signed,
    input  logic [1:0]  i_best_mode,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned GAIN_CEILING = 6;
    localparam int unsigned UTF_GAIN     = 6;
    localparam int unsigned SIGN_GAIN    = 7;

    typedef logic [cmst_pkg::SCORE_BITS-1:0] t_score;

    typedef struct packed {
        logic [31:0]     lsb6;
        logic [31:0]     msb6;
        logic [31:0]     utf8;
        logic [31:0]     sgn;
        cmst_pkg::t_mode best;
    } t_mode_scores;

    logic [7:0]   last_byte;
    logic [1:0]   utf_left;
    t_score       totals [cmst_pkg::NUM_MODES];
    t_mode_scores expected_scores [$];
    t_mode_scores oldest;
    int           fails = 0;

    // full ceiling unless the penalty catches up with the changed-bit credit
    function automatic int unsigned span_gain(input int unsigned penalty,
                                              input int unsigned credit);
        return (credit > penalty) ? GAIN_CEILING : GAIN_CEILING + credit - penalty;
    endfunction

    function automatic int unsigned sign_group(input logic [7:0] b);
        if (b == 8'h00) return 0;
        if (b < 8'h10)  return 1;
        if (b < 8'h40)  return 2;
        if (b < 8'h80)  return 3;
        if (b < 8'hC0)  return 4;
        if (b < 8'hF0)  return 5;
        if (b < 8'hFF)  return 6;
        return 7;
    endfunction

    task automatic score_byte(input logic [7:0] b, input logic ns, input logic cs);
        logic [7:0]   x;
        int unsigned  g_prev;
        int unsigned  g_cur;
        int unsigned  gap;
        int unsigned  utf_add;
        t_score       peak;
        t_mode_scores r;
        if (ns) begin
            last_byte = 8'h00;
            utf_left  = 2'd0;
        end
        if (cs) begin
            foreach (totals[m]) totals[m] = '0;
        end
        x = last_byte ^ b;
        totals[cmst_pkg::MODE_LSB6] = totals[cmst_pkg::MODE_LSB6] +
            t_score'(span_gain(3 * $countones(x & 8'hC0), $countones(x & 8'h3F)));
        totals[cmst_pkg::MODE_MSB6] = totals[cmst_pkg::MODE_MSB6] +
            t_score'(span_gain(3 * $countones(x & 8'h03), $countones(x & 8'hFC)));

        g_prev = sign_group(last_byte);
        g_cur  = sign_group(b);
        gap    = (g_cur > g_prev) ? g_cur - g_prev : g_prev - g_cur;
        totals[cmst_pkg::MODE_SIGNED] = totals[cmst_pkg::MODE_SIGNED] +
            t_score'(SIGN_GAIN - gap);

        utf_add = 0;
        if (utf_left != 2'd0) begin
            if (b[7:6] == 2'b10) begin
                utf_left = utf_left - 2'd1;
                utf_add  = UTF_GAIN;
            end else begin
                utf_left = 2'd0;
            end
        end else if (b >= 8'hF0) begin
            utf_left = 2'd3;
            utf_add  = UTF_GAIN;
        end else if (b >= 8'hE0) begin
            utf_left = 2'd2;
            utf_add  = UTF_GAIN;
        end else if (b >= 8'hC0) begin
            utf_left = 2'd1;
            utf_add  = UTF_GAIN;
        end else if (b < 8'h80) begin
            utf_add  = UTF_GAIN;
        end
        // stray continuation with nothing pending scores nothing
        totals[cmst_pkg::MODE_UTF8] = totals[cmst_pkg::MODE_UTF8] + t_score'(utf_add);
        last_byte = b;

        // first strict maximum, starting from zero
        r.best = cmst_pkg::MODE_LSB6;
        peak   = '0;
        for (int m = 0; m < cmst_pkg::NUM_MODES; m++) begin
            if (totals[m] > peak) begin
                peak   = totals[m];
                r.best = cmst_pkg::t_mode'(m);
            end
        end
        r.lsb6 = totals[cmst_pkg::MODE_LSB6][31:0];
        r.msb6 = totals[cmst_pkg::MODE_MSB6][31:0];
        r.utf8 = totals[cmst_pkg::MODE_UTF8][31:0];
        r.sgn  = totals[cmst_pkg::MODE_SIGNED][31:0];
        expected_scores.push_back(r);
    endtask

    task automatic check_field(input string field, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            last_byte = 8'h00;
            utf_left  = 2'd0;
            foreach (totals[m]) totals[m] = '0;
            expected_scores.delete();
        end else begin
            // a result always belongs to an earlier transfer, so pop first
            if (i_out_valid && i_out_ready) begin
                if (expected_scores.size() == 0) begin
                    $error("result transfer with no expected scores pending");
                    fails++;
                end else begin
                    oldest = expected_scores.pop_front();
                    check_field("score_lsb6", oldest.lsb6, i_score_lsb6);
                    check_field("score_msb6", oldest.msb6, i_score_msb6);
                    check_field("score_utf8", oldest.utf8, i_score_utf8);
                    check_field("score_signed", oldest.sgn, i_score_signed);
                    check_field("best_mode", 32'(oldest.best), 32'(i_best_mode));
                end
            end
            if (i_in_valid && i_in_ready) begin
                score_byte(i_data_byte, i_new_span, i_clear_scores);
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_scores.size();
    end

endmodule

FILE: test/context_mode_score_tracker_unit_test.sv
`timescale 1ns / 1ps

module context_mode_score_tracker_unit_test;

    localparam int IDLE_LIMIT   = 2000;
    localparam int HOLD_CYCLES  = 150;
    localparam int PHASE_ITEMS  = 280;
    localparam int SETTLE       = 8;
    localparam logic [7:0] GROUP_EDGES [10] =
        '{8'h0F, 8'h10, 8'h3F, 8'h40, 8'h7F, 8'h80, 8'hBF, 8'hEF, 8'hFE, 8'hFF};

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic [7:0]  i_data_byte    = 8'h00;
    logic        i_new_span     = 1'b0;
    logic        i_clear_scores = 1'b0;
    logic        i_out_ready    = 1'b0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [31:0] o_score_lsb6;
    logic [31:0] o_score_msb6;
    logic [31:0] o_score_utf8;
    logic [31:0] o_score_signed;
    logic [1:0]  o_best_mode;

    int   fail_count;
    int   pending;
    int   send_idle_pct = 0;
    int   stall_pct     = 0;
    logic hold_req      = 1'b0;
    logic hold_seen     = 1'b0;
    int   hold_left     = 0;
    int   idle_cycles   = 0;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    context_mode_score_tracker_unit i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_new_span     (i_new_span),
        .i_clear_scores (i_clear_scores),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_score_lsb6   (o_score_lsb6),
        .o_score_msb6   (o_score_msb6),
        .o_score_utf8   (o_score_utf8),
        .o_score_signed (o_score_signed),
        .o_best_mode    (o_best_mode)
    );

    cmst_score_checker i_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_new_span     (i_new_span),
        .i_clear_scores (i_clear_scores),
        .i_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .i_score_lsb6   (o_score_lsb6),
        .i_score_msb6   (o_score_msb6),
        .i_score_utf8   (o_score_utf8),
        .i_score_signed (o_score_signed),
        .i_best_mode    (o_best_mode),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            i_out_ready <= 1'b0;
            hold_left   <= hold_left - 1;
        end else if (hold_req != hold_seen) begin
            hold_seen   <= hold_req;
            hold_left   <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("context_mode_score_tracker_unit: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic ns, input logic cs);
        if ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_in_valid     <= 1'b1;
        i_data_byte    <= b;
        i_new_span     <= ns;
        i_clear_scores <= cs;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic send_noisy(input logic [7:0] b);
        send_byte(b, $urandom_range(0, 19) == 0, $urandom_range(0, 29) == 0);
    endtask

    // stop offering and wait for every pending result to come back
    task automatic drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
    endtask

    // mostly well-formed UTF-8 runs with random content, some broken, some noise
    task automatic random_burst(input int count);
        int         sent;
        int         kind;
        int         len;
        int         conts;
        logic [7:0] lead;
        sent = 0;
        while (sent < count) begin
            kind = $urandom_range(0, 9);
            if (kind >= 7) begin
                send_noisy(8'($urandom_range(0, 255)));
                sent++;
            end else begin
                len = (kind >= 5) ? $urandom_range(2, 4) : $urandom_range(1, 4);
                case (len)
                    1:       lead = 8'($urandom_range(8'h00, 8'h7F));
                    2:       lead = 8'($urandom_range(8'hC0, 8'hDF));
                    3:       lead = 8'($urandom_range(8'hE0, 8'hEF));
                    default: lead = 8'($urandom_range(8'hF0, 8'hFF));
                endcase
                conts = (kind >= 5) ? $urandom_range(0, len - 2) : len - 1;
                send_noisy(lead);
                sent++;
                repeat (conts) begin
                    send_noisy(8'($urandom_range(8'h80, 8'hBF)));
                    sent++;
                end
                if (kind >= 5) begin
                    send_noisy($urandom_range(0, 1) ? 8'($urandom_range(8'h00, 8'h7F))
                                                    : 8'($urandom_range(8'hC0, 8'hFF)));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: flag combinations, lowest/highest adds, ties, UTF-8 shapes
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b0, 1'b0);
        send_byte(8'h00, 1'b0, 1'b0);
        send_byte(8'hC0, 1'b0, 1'b0);
        send_byte(8'h03, 1'b1, 1'b1);
        send_byte(8'h01, 1'b1, 1'b1);
        send_byte(8'hE2, 1'b0, 1'b0);
        send_byte(8'h82, 1'b0, 1'b0);
        send_byte(8'hAC, 1'b0, 1'b0);
        send_byte(8'hF0, 1'b0, 1'b0);
        send_byte(8'h9F, 1'b0, 1'b0);
        send_byte(8'h98, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        send_byte(8'hA9, 1'b0, 1'b0);
        send_byte(8'h80, 1'b0, 1'b0);
        send_byte(8'hE2, 1'b0, 1'b0);
        send_byte(8'h41, 1'b0, 1'b0);
        // new span while continuations pending: the next 0x80 is stray
        send_byte(8'hF4, 1'b0, 1'b0);
        send_byte(8'h80, 1'b1, 1'b0);
        foreach (GROUP_EDGES[i]) send_byte(GROUP_EDGES[i], 1'b0, 1'b0);
        drain();

        // back-to-back, with one long output hold-off to fill the block
        hold_req <= ~hold_req;
        random_burst(PHASE_ITEMS);
        drain();

        send_idle_pct = 67;
        random_burst(PHASE_ITEMS);
        drain();

        send_idle_pct = 0;
        stall_pct    <= 67;
        random_burst(PHASE_ITEMS);
        drain();

        send_idle_pct = 37;
        stall_pct    <= 37;
        random_burst(PHASE_ITEMS);
        drain();

        repeat (SETTLE) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("context_mode_score_tracker_unit: match");
        end else begin
            $display("context_mode_score_tracker_unit: mismatch");
        end
        $finish;
    end

endmodule
